FILE: rtl/core/stbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sky tile search package
// Widths, request codes and shared types of the sky tile binary search.
// ----------------------------------------------------------------------------
package stbs_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int PTR_W       = ADDR_W + 1;
   localparam int COUNT_W     = 13;
   localparam int SPAN_W      = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;
   localparam int INDEX_W     = 12;
   localparam int RA_W        = 29;
   localparam int DEC_W       = 28;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic [RA_W-1:0]         ra_low;
      logic [RA_W-1:0]         ra_high;
      logic signed [DEC_W-1:0] dec_low;
      logic signed [DEC_W-1:0] dec_high;
   } tile_type;

   typedef struct packed {
      logic below;
      logic above;
   } probe_type;

endpackage

FILE: rtl/core/stbs_tile_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile table memory
// One write port and one registered read port over the tile bounds.
// ----------------------------------------------------------------------------
module stbs_tile_mem (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [stbs_pkg::ADDR_W-1:0] wr_addr,
   input  stbs_pkg::tile_type         wr_data,
   input  logic                       rd_en,
   input  logic [stbs_pkg::ADDR_W-1:0] rd_addr,
   output stbs_pkg::tile_type         rd_data
);

   stbs_pkg::tile_type mem [stbs_pkg::TABLE_DEPTH];
   stbs_pkg::tile_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/stbs_probe_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Probe comparator
// Places the point before, after or inside one tile: Dec first, then RA.
// ----------------------------------------------------------------------------
module stbs_probe_cmp (
   input  stbs_pkg::tile_type                  tile,
   input  logic [stbs_pkg::RA_W-1:0]           point_ra,
   input  logic signed [stbs_pkg::DEC_W-1:0]   point_dec,
   output stbs_pkg::probe_type                 result
);

   logic dec_lt;
   logic dec_ge;
   logic ra_lt;
   logic ra_ge;

   assign dec_lt = point_dec <  tile.dec_low;
   assign dec_ge = point_dec >= tile.dec_high;
   assign ra_lt  = point_ra  <  tile.ra_low;
   assign ra_ge  = point_ra  >= tile.ra_high;

   // The lower Dec bound wins over everything; the RA lower bound wins over
   // the RA upper bound.
   assign result.below = dec_lt | (~dec_ge & ra_lt);
   assign result.above = ~dec_lt & (dec_ge | (~ra_lt & ra_ge));

endmodule

FILE: rtl/core/stbs_search_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Search sequencer
// Runs the bisection, one memory read and one compare per probe, and holds
// the result register.
// ----------------------------------------------------------------------------
module stbs_search_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [stbs_pkg::RA_W-1:0]           req_point_ra,
   input  logic signed [stbs_pkg::DEC_W-1:0]   req_point_dec,
   input  logic [stbs_pkg::COUNT_W-1:0]        brick_count,
   output logic                                rd_en,
   output logic [stbs_pkg::ADDR_W-1:0]         rd_addr,
   input  stbs_pkg::tile_type                  rd_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [stbs_pkg::INDEX_W-1:0]        rsp_tile_index
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_CMP  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;

   logic [stbs_pkg::PTR_W-1:0]         lo_ff, lo_in;
   logic [stbs_pkg::PTR_W-1:0]         hi_ex_ff, hi_ex_in;
   logic [stbs_pkg::ADDR_W-1:0]        mid_ff, mid_in;
   logic [stbs_pkg::RA_W-1:0]          point_ra_ff, point_ra_in;
   logic signed [stbs_pkg::DEC_W-1:0]  point_dec_ff, point_dec_in;
   logic                               hit_ff, hit_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_found_ff, rsp_found_in;
   logic [stbs_pkg::INDEX_W-1:0]       rsp_index_ff, rsp_index_in;

   logic [stbs_pkg::SPAN_W-1:0]                    count_wide;
   logic [stbs_pkg::PTR_W-1:0]                     count_sat;
   logic [stbs_pkg::PTR_W:0]                       mid_sum;
   logic [stbs_pkg::ADDR_W-1:0]                    mid;
   logic [stbs_pkg::ADDR_W+stbs_pkg::INDEX_W-1:0]  mid_pad;
   logic                                           out_free;
   stbs_pkg::probe_type                            probe;

   stbs_probe_cmp u_cmp (
      .tile      (rd_data),
      .point_ra  (point_ra_ff),
      .point_dec (point_dec_ff),
      .result    (probe)
   );

   // A count above the table depth is clipped to the depth.
   assign count_wide = stbs_pkg::SPAN_W'(brick_count);
   assign count_sat  = (count_wide > stbs_pkg::SPAN_W'(stbs_pkg::TABLE_DEPTH)) ?
                       stbs_pkg::PTR_W'(stbs_pkg::TABLE_DEPTH) :
                       count_wide[stbs_pkg::PTR_W-1:0];

   // The upper bound is exclusive, so the midpoint is (lo + hi_ex - 1) / 2.
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ex_ff} - (stbs_pkg::PTR_W+1)'(1);
   assign mid     = mid_sum[stbs_pkg::ADDR_W:1];
   assign mid_pad = {{stbs_pkg::INDEX_W{1'b0}}, mid_ff};

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rd_en     = (state_ff == S_READ) && (lo_ff < hi_ex_ff);
   assign rd_addr   = mid;

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_ex_in     = hi_ex_ff;
      mid_in       = mid_ff;
      point_ra_in  = point_ra_ff;
      point_dec_in = point_dec_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_func == stbs_pkg::FUNC_QUERY) begin
               lo_in        = '0;
               hi_ex_in     = count_sat;
               hit_in       = 1'b0;
               point_ra_in  = req_point_ra;
               point_dec_in = req_point_dec;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            if (lo_ff < hi_ex_ff) begin
               mid_in   = mid;
               state_in = S_CMP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CMP: begin
            priority if (probe.above) begin
               lo_in    = {1'b0, mid_ff} + stbs_pkg::PTR_W'(1);
               state_in = S_READ;
            end else if (probe.below) begin
               hi_ex_in = {1'b0, mid_ff};
               state_in = S_READ;
            end else begin
               hit_in   = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_index_in = hit_ff ? mid_pad[stbs_pkg::INDEX_W-1:0] : '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ex_ff     <= hi_ex_in;
      mid_ff       <= mid_in;
      point_ra_ff  <= point_ra_in;
      point_dec_ff <= point_dec_in;
      hit_ff       <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_tile_index = rsp_index_ff;

   // The search window never reaches past the table.
   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_CMP) |->
         (hi_ex_ff <= stbs_pkg::PTR_W'(stbs_pkg::TABLE_DEPTH)))
      else $error("search window beyond table depth");

   // The probed slot lies inside the window.
   a_mid_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |->
         (lo_ff <= {1'b0, mid_ff} && {1'b0, mid_ff} < hi_ex_ff))
      else $error("probe outside search window");

   // Every miss shrinks the window, so the search ends.
   a_window_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP && (probe.above || probe.below)) |=>
         ((hi_ex_ff - lo_ff) < ($past(hi_ex_ff) - $past(lo_ff))))
      else $error("search window did not shrink");

   // A result appears only at the end of a search.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside the done state");

endmodule

FILE: rtl/core/sky_tile_binary_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sky tile binary search
// Sorted table of RA/Dec tiles, searched by bisection for a point.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel. A load request (func 0) writes one
// tile into the table in the cycle it is accepted and gives no response; a
// slot at or above the table depth is ignored. A query request (func 1)
// bisects the first csr_brick_count slots, at most the table depth, and
// returns one response on the rsp_ channel: rsp_found and rsp_tile_index
// (zero when nothing matches). A query makes P probes, where P is at most
// floor(log2(count)) + 1. Each probe costs one read of the single table
// read port plus one compare. Only one request is in flight, and req_ready
// is low while a query runs. A finished result waits in an output register;
// a new request is taken while it waits, but a second query result waits
// until the first one has been taken. The user writes csr_brick_count
// through the csr_ port only while the block is idle; the block itself does
// not enforce this. Reset clears the count and the control state; the tile
// table keeps no reset value and slots must be loaded before they are read.
// ----------------------------------------------------------------------------
module sky_tile_binary_search (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [stbs_pkg::COUNT_W-1:0]        csr_brick_count,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [11:0]                         req_entry_index,
   input  logic [stbs_pkg::RA_W-1:0]           req_tile_ra_low,
   input  logic [stbs_pkg::RA_W-1:0]           req_tile_ra_high,
   input  logic signed [stbs_pkg::DEC_W-1:0]   req_tile_dec_low,
   input  logic signed [stbs_pkg::DEC_W-1:0]   req_tile_dec_high,
   input  logic [stbs_pkg::RA_W-1:0]           req_point_ra,
   input  logic signed [stbs_pkg::DEC_W-1:0]   req_point_dec,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [stbs_pkg::INDEX_W-1:0]        rsp_tile_index
);

   logic [stbs_pkg::COUNT_W-1:0]             brick_count_ff;
   logic                                     wr_en;
   logic [stbs_pkg::ADDR_W+11:0]             wr_addr_pad;
   stbs_pkg::tile_type                       wr_data;
   logic                                     rd_en;
   logic [stbs_pkg::ADDR_W-1:0]              rd_addr;
   stbs_pkg::tile_type                       rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         brick_count_ff <= '0;
      end else if (csr_valid) begin
         brick_count_ff <= csr_brick_count;
      end
   end

   assign wr_en = req_valid && req_ready && (req_func == stbs_pkg::FUNC_LOAD) &&
                  (32'(req_entry_index) < stbs_pkg::TABLE_DEPTH);
   assign wr_addr_pad = {{stbs_pkg::ADDR_W{1'b0}}, req_entry_index};

   assign wr_data.ra_low   = req_tile_ra_low;
   assign wr_data.ra_high  = req_tile_ra_high;
   assign wr_data.dec_low  = req_tile_dec_low;
   assign wr_data.dec_high = req_tile_dec_high;

   stbs_tile_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr_pad[stbs_pkg::ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   stbs_search_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_point_ra   (req_point_ra),
      .req_point_dec  (req_point_dec),
      .brick_count    (brick_count_ff),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_tile_index (rsp_tile_index)
   );

endmodule
